// ===== src/bglp_pkg.sv =====
// shared types and constants of the lipo battery gauge
// curve tables, register indexes, controller states and command/status words
// no dependencies
package bglp_pkg;

  localparam int SAMPLE_BITS_DEF    = 12;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int GAIN_W     = 16;
  localparam int COUNT_W    = 8;
  localparam int N_W        = COUNT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_GAIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_GAIN   = 8'd3;

  localparam logic [COUNT_W-1:0] COUNT_RESET   = 8'd16;
  localparam logic [GAIN_W-1:0]  DIVIDER_RESET = 16'd8192;
  localparam logic [GAIN_W-1:0]  CALIB_RESET   = 16'd4096;

  localparam int CURVE_POINTS = 13;
  localparam int SEG_W        = 4;
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    16'd3000, 16'd3300, 16'd3500, 16'd3610, 16'd3690, 16'd3750, 16'd3790,
    16'd3830, 16'd3870, 16'd3950, 16'd4110, 16'd4150, 16'd4200
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50,
    7'd60, 7'd70, 7'd80, 7'd90, 7'd95, 7'd100
  };

  localparam logic [MV_W-1:0]  VALID_MIN_MV = 16'd2500;
  localparam logic [MV_W-1:0]  VALID_MAX_MV = 16'd4350;
  localparam logic [MV_W-1:0]  MV_SAT       = 16'hFFFF;
  localparam logic [PCT_W-1:0] PCT_EMPTY    = 7'd0;
  localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;

  // shared divider: 16 quotient bits, 4 per step
  localparam int DIV_Q_W    = 16;
  localparam int DIV_D_W    = 10;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = DIV_Q_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int OFF_W      = DIV_D_W - 1;
  localparam int DP_W       = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_DIV_MV,
    ST_SEG,
    ST_NUMER,
    ST_DIV_PCT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic load_mv;
    logic step;
    logic seg;
    logic load_pct;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic out_busy;
  } status_t;

endpackage

// ===== src/bglp_div.sv =====
// shared restoring divider, several quotient bits per step
// depends on bglp_pkg
module bglp_div (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [bglp_pkg::DIV_D_W-1:0] rem_init,
  input  logic [bglp_pkg::DIV_Q_W-1:0] dividend,
  input  logic [bglp_pkg::DIV_D_W-1:0] divisor,
  output logic [bglp_pkg::DIV_Q_W-1:0] quotient
);
  import bglp_pkg::*;

  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [DIV_Q_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_D_W-1:0] dvs_r;
  logic [DIV_Q_W-1:0] quo_r;
  logic [DIV_BITS-1:0] qbits;

  always_comb begin
    logic [DIV_D_W:0] trial;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    qbits   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial   = {rem_nxt, dvd_nxt[DIV_Q_W-1]};
      dvd_nxt = {dvd_nxt[DIV_Q_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial = trial - {1'b0, dvs_r};
        qbits = {qbits[DIV_BITS-2:0], 1'b1};
      end else begin
        qbits = {qbits[DIV_BITS-2:0], 1'b0};
      end
      rem_nxt = trial[DIV_D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= rem_init;
      dvd_r <= dividend;
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (step) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      quo_r <= {quo_r[DIV_Q_W-DIV_BITS-1:0], qbits};
    end
  end

  assign quotient = quo_r;

endmodule

// ===== src/bglp_ctrl.sv =====
// controller of the battery gauge: sequences scaling, divides and curve lookup
// depends on bglp_pkg
module bglp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bglp_pkg::status_t   sts,
  output bglp_pkg::cmd_t      cmd
);
  import bglp_pkg::*;

  state_t state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic last_step;

  assign last_step = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && sts.complete) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.load_mv = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_DIV_MV;
      end
      ST_DIV_MV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_step) state_nxt = ST_SEG;
      end
      ST_SEG: begin
        cmd.seg   = 1'b1;
        state_nxt = ST_NUMER;
      end
      ST_NUMER: begin
        cmd.load_pct = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV_PCT;
      end
      ST_DIV_PCT: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_step) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && in_valid && sts.complete |=> state_r == ST_MUL)
    else $error("completing word did not start scaling");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV_MV && last_step |=> state_r == ST_SEG)
    else $error("voltage divide did not end after its last step");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("input not stalled while a reading runs");
`endif

endmodule

// ===== src/bglp_datapath.sv =====
// datapath of the battery gauge: config registers, accumulator, scaling,
// curve interpolation and output register; depends on bglp_pkg and bglp_div
module bglp_datapath #(
  parameter int SAMPLE_BITS    = bglp_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = bglp_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bglp_pkg::cmd_t                  cmd,
  output bglp_pkg::status_t               sts,
  input  logic [SAMPLE_BITS-1:0]          in_sample_mv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bglp_pkg::MV_W-1:0]       out_battery_mv,
  output logic                            out_reading_valid,
  output logic [bglp_pkg::PCT_W-1:0]      out_percent,
  input  logic                            cfg_valid,
  input  logic [bglp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bglp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bglp_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + COUNT_W;
  localparam int PROD_W = 2 * GAIN_W;
  localparam int NUM_W  = SUM_W + PROD_W;
  localparam int RND_W  = NUM_W + 1;
  localparam int SHIFT  = 2 * GAIN_FRAC_BITS;
  localparam int T_W    = RND_W - SHIFT;
  localparam int HI_W   = T_W - DIV_Q_W;
  localparam int CMP_W  = (HI_W > N_W) ? HI_W : N_W;

  logic               enabled_r;
  logic [COUNT_W-1:0] count_r;
  logic [GAIN_W-1:0]  dgain_r, cgain_r;
  logic [PROD_W-1:0]  prod_r;
  logic [SUM_W-1:0]   sum_r, acc_r, sum_add;
  logic [COUNT_W-1:0] taken_r, taken_inc, target;
  logic [N_W-1:0]     n_r, n_nxt;
  logic [NUM_W-1:0]   num_r;
  logic               sat_r, valid_r, lo_r, hi_r;
  logic [MV_W-1:0]    mv_r;
  logic [SEG_W-1:0]   seg_r;
  logic [PCT_W-1:0]   base_r, last_pct_r;
  logic               out_valid_r;
  logic [MV_W-1:0]    out_mv_r;
  logic               out_rv_r;
  logic [PCT_W-1:0]   out_pct_r;

  // accumulation
  assign sum_add   = sum_r + SUM_W'(in_sample_mv);
  assign taken_inc = taken_r + 1'b1;
  assign target    = (count_r == '0) ? COUNT_W'(1) : count_r;
  assign n_nxt     = (taken_inc == '0) ? N_W'(1 << COUNT_W) : {1'b0, taken_inc};
  assign sts.complete = enabled_r && !((taken_inc < target) && (taken_inc != '0));
  assign sts.out_busy = out_valid_r && out_stall;

  // rounding and saturation test ahead of the voltage divide
  logic [RND_W-1:0] rnd;
  logic [T_W-1:0]   tq;
  logic [CMP_W-1:0] hi_ext;
  logic             sat_w;
  assign rnd    = RND_W'(num_r) + (RND_W'(n_r) << (SHIFT - 1));
  assign tq     = rnd[RND_W-1:SHIFT];
  assign hi_ext = CMP_W'(tq[T_W-1:DIV_Q_W]);
  assign sat_w  = hi_ext >= CMP_W'(n_r);

  // segment search on the scaled voltage
  logic [DIV_Q_W-1:0] quo;
  logic [MV_W-1:0]    mv_w;
  logic [SEG_W-1:0]   seg_w;
  assign mv_w = sat_r ? MV_SAT : quo;

  always_comb begin
    seg_w = SEG_W'(CURVE_POINTS - 1);
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (mv_w <= CURVE_MV[i]) seg_w = SEG_W'(i);
    end
  end

  // interpolation numerator and denominator
  logic [SEG_W-1:0]   idx_lo;
  logic [MV_W-1:0]    off_full, dv_full;
  logic [PCT_W-1:0]   dp_full;
  logic [OFF_W-1:0]   off, dv;
  logic [DP_W-1:0]    dp;
  logic [DIV_Q_W-1:0] numer;
  assign idx_lo   = seg_r - 1'b1;
  assign off_full = mv_r - CURVE_MV[idx_lo];
  assign dv_full  = CURVE_MV[seg_r] - CURVE_MV[idx_lo];
  assign dp_full  = CURVE_PCT[seg_r] - CURVE_PCT[idx_lo];
  assign off      = off_full[OFF_W-1:0];
  assign dv       = dv_full[OFF_W-1:0];
  assign dp       = dp_full[DP_W-1:0];
  assign numer    = DIV_Q_W'({off, 1'b0}) * DIV_Q_W'(dp) + DIV_Q_W'(dv);

  logic [DIV_D_W-1:0] div_rem;
  logic [DIV_Q_W-1:0] div_dvd;
  logic [DIV_D_W-1:0] div_dvs;
  always_comb begin
    if (cmd.load_pct) begin
      div_rem = '0;
      div_dvd = numer;
      div_dvs = {dv, 1'b0};
    end else begin
      div_rem = sat_w ? '0 : DIV_D_W'(hi_ext[N_W-1:0]);
      div_dvd = tq[DIV_Q_W-1:0];
      div_dvs = DIV_D_W'(n_r);
    end
  end

  bglp_div u_div (
    .clk      (clk),
    .load     (cmd.load_mv || cmd.load_pct),
    .step     (cmd.step),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (quo)
  );

  logic [PCT_W-1:0] pct_w;
  always_comb begin
    if (!valid_r)  pct_w = last_pct_r;
    else if (lo_r) pct_w = PCT_EMPTY;
    else if (hi_r) pct_w = PCT_FULL;
    else           pct_w = base_r + quo[PCT_W-1:0];
  end

  // configuration and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      count_r    <= COUNT_RESET;
      dgain_r    <= DIVIDER_RESET;
      cgain_r    <= CALIB_RESET;
      sum_r      <= '0;
      taken_r    <= '0;
      last_pct_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ENABLED:      enabled_r <= cfg_data[0];
          REG_SAMPLE_COUNT: count_r   <= cfg_data[COUNT_W-1:0];
          REG_DIVIDER_GAIN: dgain_r   <= cfg_data[GAIN_W-1:0];
          REG_CALIB_GAIN:   cgain_r   <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && enabled_r) begin
        if (sts.complete) begin
          sum_r   <= '0;
          taken_r <= '0;
        end else begin
          sum_r   <= sum_add;
          taken_r <= taken_inc;
        end
      end
      if (cmd.finish) begin
        last_pct_r  <= pct_w;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prod_r <= dgain_r * cgain_r;
    if (cmd.accept && sts.complete) begin
      acc_r <= sum_add;
      n_r   <= n_nxt;
    end
    if (cmd.mul) num_r <= acc_r * prod_r;
    if (cmd.load_mv) sat_r <= sat_w;
    if (cmd.seg) begin
      mv_r    <= mv_w;
      seg_r   <= seg_w;
      valid_r <= (mv_w >= VALID_MIN_MV) && (mv_w <= VALID_MAX_MV);
      lo_r    <= mv_w <= CURVE_MV[0];
      hi_r    <= mv_w >= CURVE_MV[CURVE_POINTS-1];
    end
    if (cmd.load_pct) base_r <= CURVE_PCT[idx_lo];
    if (cmd.finish) begin
      out_mv_r  <= mv_r;
      out_rv_r  <= valid_r;
      out_pct_r <= pct_w;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_battery_mv    = out_mv_r;
  assign out_reading_valid = out_rv_r;
  assign out_percent       = out_pct_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("result written over a stalled word");
  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rv_r |-> out_mv_r >= VALID_MIN_MV && out_mv_r <= VALID_MAX_MV)
    else $error("reading flagged valid outside the voltage window");
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pct_r <= PCT_FULL)
    else $error("percentage above full");
`endif

endmodule

// ===== src/battery_gauge_lipo_percent_top.sv =====
// lipo battery gauge top level: averages converter samples, scales them to a
// battery voltage and looks up the charge percentage on a 13-point curve
// depends on bglp_pkg, bglp_ctrl, bglp_datapath
//
// input channel: one sample word per handshake (in_valid high, in_stall low).
// while enabled, samples are summed; the word that completes sample_count
// samples starts a reading, other words are taken in one cycle each. while
// disabled, words are taken and dropped.
// a completing word yields one result word after a gain multiply, a rounding
// step, a 4-step voltage divide, segment search, interpolation setup and a
// 4-step interpolation divide; both divides use one shared divider. in_stall
// is high during that sequence.
// result channel: out_valid holds the word in an output register until
// out_stall is low; the next reading may run meanwhile and waits at its end
// only if the register is still occupied.
// configuration: cfg_ready is always high; writes are meant for idle times.
// reset (rst_n low, synchronous) clears the sum, count, stored percentage and
// output valid and restores register defaults.
module battery_gauge_lipo_percent_top #(
  parameter int SAMPLE_BITS    = bglp_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = bglp_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          in_sample_mv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bglp_pkg::MV_W-1:0]       out_battery_mv,
  output logic                            out_reading_valid,
  output logic [bglp_pkg::PCT_W-1:0]      out_percent,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bglp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bglp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bglp_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  bglp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bglp_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample_mv      (in_sample_mv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_battery_mv    (out_battery_mv),
    .out_reading_valid (out_reading_valid),
    .out_percent       (out_percent),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

endmodule
